// File: design/dhfk_pkg.sv
// Shared types, constants and the arctangent table of the DH forward kinematics core.
package dhfk_pkg;

   localparam int ANGLE_W      = 19;         // joint angle plus offset
   localparam int DEG360       = 46080;      // one turn in 1/128 degree
   localparam int MOD_BIAS     = 276480;     // six turns, makes any angle sum positive
   localparam int PHASE_DIV    = 45;         // 46080 / 1024
   localparam int PHASE_ROUND  = 22;         // 23040 / 1024, truncated
   localparam int RECIP45_HI   = 46604;      // 2^21 / 45, rounded up
   localparam int RECIP45_LO   = 1457;       // 2^16 / 45, rounded up
   localparam int FRAC_STEP    = 93206;      // 2^22 / 45, truncated
   localparam int FRAC_REM     = 34;         // 2^22 mod 45
   localparam int DIV_CYCLES   = 3;          // quotient, remainder and phase in turn
   localparam int JR_OPS       = 6;          // products that build the joint transform
   localparam int MAC_OPS      = 54;         // six joint products and 48 matrix terms
   localparam int DRAIN_CYCLES = 2;
   localparam int NUM_ENTRIES  = 12;
   localparam logic [3:0] LAST_ENTRY = 4'd11;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DIVIDE,
      ST_FOLD,
      ST_ROTATE,
      ST_FINISH,
      ST_MAC,
      ST_DRAIN,
      ST_COMMIT,
      ST_EMIT
   } dhfk_state_type;

   typedef struct packed {
      logic       load;
      logic       reduce;
      logic       div_step;
      logic       fold;
      logic       rot_step;
      logic [4:0] rot_idx;
      logic       finish;
      logic       issue;
      logic [5:0] op;
      logic       commit;
      logic       load_out;
      logic [3:0] out_idx;
   } dhfk_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_joint;
   } dhfk_status_type;

   // Arctangent of 2^-i in binary angle units (2^32 per turn).
   function automatic logic [31:0] atan_value(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: design/dhfk_sincos.sv
// Angle reduction, phase division by a constant and rotation-mode CORDIC for one angle.
module dhfk_sincos import dhfk_pkg::*; (
   input  logic                      clock,
   input  dhfk_cmd_type              cmd,
   input  logic signed [ANGLE_W-1:0] angle,
   output logic signed [31:0]        sin_val,
   output logic signed [31:0]        cos_val
);

   logic [15:0]        red_ff, red_in;
   logic [9:0]         quo_ff, quo_in;
   logic [5:0]         rem_ff, rem_in;
   logic [31:0]        phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic signed [31:0] sin_ff, sin_in;
   logic signed [31:0] cos_ff, cos_in;

   always_comb begin
      logic [19:0]        red;
      logic [31:0]        quo_prod;
      logic [10:0]        frac_num;
      logic [21:0]        frac_prod;
      logic [31:0]        phase;
      logic [31:0]        chk;
      logic signed [33:0] dx, dy, at, xv, yv;
      red_in   = red_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      red      = 20'({angle[ANGLE_W-1], angle}) + 20'(MOD_BIAS);
      for (int q = 3; q >= 0; q--) begin
         if (red >= (20'(DEG360) << q)) begin
            red = red - (20'(DEG360) << q);
         end
      end
      quo_prod  = 32'(red_ff) * 32'(RECIP45_HI);
      frac_num  = 11'(rem_ff) * 11'(FRAC_REM) + 11'(PHASE_ROUND);
      frac_prod = 22'(frac_num) * 22'(RECIP45_LO);
      phase     = phase_ff;
      chk       = phase + 32'h4000_0000;
      dx        = y_ff >>> cmd.rot_idx;
      dy        = x_ff >>> cmd.rot_idx;
      at        = 34'(atan_value(cmd.rot_idx));
      xv        = neg_ff ? -x_ff : x_ff;
      yv        = neg_ff ? -y_ff : y_ff;
      if (cmd.reduce) begin
         red_in = red[15:0];
      end
      if (cmd.div_step) begin
         // With the reduced angle r = 45q + m, the phase is q * 2^22 plus the share of m,
         // which splits into whole steps of 2^22 / 45 and a small remainder term.
         quo_in   = quo_prod[30:21];
         rem_in   = 6'(red_ff - 16'(quo_ff) * 16'(PHASE_DIV));
         phase_in = {quo_ff, 22'd0} + 32'(rem_ff) * 32'(FRAC_STEP) + 32'(frac_prod[21:16]);
      end
      if (cmd.fold) begin
         // The half turn around 180 degrees is folded onto the CORDIC's range.
         neg_in = chk[31];
         if (chk[31]) begin
            phase = phase + 32'h8000_0000;
         end
         z_in = 34'(signed'(phase));
         x_in = CORDIC_GAIN;
         y_in = '0;
      end
      if (cmd.rot_step) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
      end
      if (cmd.finish) begin
         if (xv > 34'(Q30_ONE)) cos_in = Q30_ONE;
         else if (xv < -34'(Q30_ONE)) cos_in = -Q30_ONE;
         else cos_in = 32'(xv);
         if (yv > 34'(Q30_ONE)) sin_in = Q30_ONE;
         else if (yv < -34'(Q30_ONE)) sin_in = -Q30_ONE;
         else sin_in = 32'(yv);
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      phase_ff <= phase_in;
      neg_ff   <= neg_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

// File: design/dhfk_datapath.sv
// Datapath: joint registers, two sine/cosine units, shared multiply-accumulate and transforms.
module dhfk_datapath import dhfk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dhfk_cmd_type       cmd,
   input  logic signed [17:0] joint_angle,
   input  logic signed [17:0] angle_offset,
   input  logic signed [17:0] twist_angle,
   input  logic signed [23:0] link_length,
   input  logic signed [23:0] link_offset,
   input  logic               last_joint,
   input  logic               rsp_tready,
   output dhfk_status_type    status,
   output logic               rsp_tvalid,
   output logic [3:0]         entry_index,
   output logic signed [31:0] entry_value,
   output logic               last_entry
);

   logic signed [ANGLE_W-1:0] theta_ff, alpha_ff;
   logic signed [23:0]        alen_ff, doff_ff;
   logic                      last_ff;
   logic signed [31:0]        st, ct, sa, ca;
   logic signed [31:0]        jr1_ff, jr2_ff, jr4_ff, jr5_ff, jt0_ff, jt1_ff;
   logic signed [31:0]        running_ff [NUM_ENTRIES];
   logic signed [31:0]        next_ff [NUM_ENTRIES];
   logic signed [31:0]        op_a, op_b;
   logic signed [63:0]        prod_ff, prod_in;
   logic                      t1_valid_ff, t1_first_ff, t1_last_ff;
   logic [4:0]                t1_dest_ff;
   logic                      t1_first_in, t1_last_in;
   logic [4:0]                t1_dest_in;
   logic signed [63:0]        acc_ff;
   logic                      fin_valid_ff;
   logic [4:0]                fin_dest_ff;
   logic signed [63:0]        rnd_wide;
   logic signed [33:0]        rnd;
   logic signed [31:0]        sat;
   logic                      rsp_valid_ff;
   logic [3:0]                out_idx_ff;
   logic signed [31:0]        out_val_ff;
   logic                      out_last_ff;

   dhfk_sincos u_theta (
      .clock   (clock),
      .cmd     (cmd),
      .angle   (theta_ff),
      .sin_val (st),
      .cos_val (ct)
   );

   dhfk_sincos u_alpha (
      .clock   (clock),
      .cmd     (cmd),
      .angle   (alpha_ff),
      .sin_val (sa),
      .cos_val (ca)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         theta_ff <= ANGLE_W'(joint_angle) + ANGLE_W'(angle_offset);
         alpha_ff <= ANGLE_W'(twist_angle);
         alen_ff  <= link_length;
         doff_ff  <= link_offset;
         last_ff  <= last_joint;
      end
   end

   // Operand selection: six joint products first, then four terms per new entry.
   always_comb begin
      logic [5:0] m;
      logic [3:0] e;
      logic [1:0] k, r, c;
      m = cmd.op - 6'(JR_OPS);
      e = m[5:2];
      k = m[1:0];
      r = e[3:2];
      c = e[1:0];
      op_a = '0;
      op_b = '0;
      t1_first_in = 1'b1;
      t1_last_in  = 1'b1;
      t1_dest_in  = 5'(cmd.op);
      if (cmd.op < 6'(JR_OPS)) begin
         case (cmd.op[2:0])
            3'd0: begin op_a = st; op_b = ca; end
            3'd1: begin op_a = st; op_b = sa; end
            3'd2: begin op_a = ct; op_b = ca; end
            3'd3: begin op_a = ct; op_b = sa; end
            3'd4: begin op_a = 32'(alen_ff); op_b = ct; end
            default: begin op_a = 32'(alen_ff); op_b = st; end
         endcase
      end else begin
         op_a = running_ff[{r, k}];
         case ({k, c})
            4'b00_00: op_b = ct;
            4'b00_01: op_b = jr1_ff;
            4'b00_10: op_b = jr2_ff;
            4'b00_11: op_b = jt0_ff;
            4'b01_00: op_b = st;
            4'b01_01: op_b = jr4_ff;
            4'b01_10: op_b = jr5_ff;
            4'b01_11: op_b = jt1_ff;
            4'b10_01: op_b = sa;
            4'b10_10: op_b = ca;
            4'b10_11: op_b = 32'(doff_ff);
            // The old translation enters as one more term scaled by one.
            4'b11_11: op_b = Q30_ONE;
            default:  op_b = '0;
         endcase
         t1_first_in = (k == 2'd0);
         t1_last_in  = (k == 2'd3);
         t1_dest_in  = 5'(JR_OPS) + 5'(e);
      end
      prod_in = op_a * op_b;
   end

   assign rnd_wide = acc_ff + 64'sd536870912;
   assign rnd      = rnd_wide[63:30];

   always_comb begin
      if (rnd > 34'sd2147483647) sat = 32'sh7fff_ffff;
      else if (rnd < -34'sd2147483648) sat = 32'sh8000_0000;
      else sat = 32'(rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff  <= cmd.issue;
         fin_valid_ff <= t1_valid_ff && t1_last_ff;
      end
      prod_ff     <= prod_in;
      t1_first_ff <= t1_first_in;
      t1_last_ff  <= t1_last_in;
      t1_dest_ff  <= t1_dest_in;
      fin_dest_ff <= t1_dest_ff;
      if (t1_valid_ff) begin
         acc_ff <= t1_first_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_ff) begin
         case (fin_dest_ff)
            5'd0: jr1_ff <= -sat;
            5'd1: jr2_ff <= sat;
            5'd2: jr4_ff <= sat;
            5'd3: jr5_ff <= -sat;
            5'd4: jt0_ff <= sat;
            5'd5: jt1_ff <= sat;
            default: next_ff[4'(fin_dest_ff - 5'(JR_OPS))] <= sat;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.commit && last_ff)) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            running_ff[i] <= (i == 0 || i == 5 || i == 10) ? Q30_ONE : '0;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            running_ff[i] <= next_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_idx_ff  <= cmd.out_idx;
         out_val_ff  <= next_ff[cmd.out_idx];
         out_last_ff <= (cmd.out_idx == LAST_ENTRY);
      end
   end

   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.last_joint = last_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign entry_index = out_idx_ff;
   assign entry_value = out_val_ff;
   assign last_entry  = out_last_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while an item still waits");
   a_drained_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!t1_valid_ff && !fin_valid_ff && !cmd.issue))
      else $error("transform committed before the accumulator drained");
   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_last_ff == (out_idx_ff == LAST_ENTRY)))
      else $error("last entry flag out of step with the entry index");
`endif

endmodule

// File: design/dhfk_ctrl.sv
// Controller: sequences reduction, division, CORDIC, multiply-accumulate and result output.
module dhfk_ctrl import dhfk_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  dhfk_status_type status,
   output dhfk_cmd_type    cmd
);

   dhfk_state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            cnt_in     = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 6'(DIV_CYCLES - 1)) state_in = ST_FOLD;
            else cnt_in = cnt_ff + 6'd1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rot_step = 1'b1;
            cmd.rot_idx  = cnt_ff[4:0];
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) state_in = ST_FINISH;
            else cnt_in = cnt_ff + 6'd1;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            cnt_in     = '0;
            state_in   = ST_MAC;
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            cmd.op    = cnt_ff;
            if (cnt_ff == 6'(MAC_OPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == 6'(DRAIN_CYCLES - 1)) state_in = ST_COMMIT;
            else cnt_in = cnt_ff + 6'd1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            cnt_in     = '0;
            state_in   = status.last_joint ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_idx  = cnt_ff[3:0];
               cnt_in       = cnt_ff + 6'd1;
               if (cnt_ff[3:0] == LAST_ENTRY) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: design/dh_forward_kinematics_core.sv
// Top level of the DH forward kinematics core: stream ports, controller and datapath.
//
//   Channel  Direction  Payload
//   req_     in         one joint row: angles, link length and offset, last joint on tlast
//   rsp_     out        one transform entry: index and value, last entry on tlast
//
// An item is taken through angle reduction, phase division and the half-turn fold, then
// CORDIC_STEPS rotations and 54 passes through the single 32x32 multiply-accumulate unit.
// A last joint then sends twelve items, one per cycle while rsp_tready stays high.
// Synchronous reset sets the running transform to identity and empties the result register.
// The result register holds its item through stalls; the next row is taken after the last load.
module dh_forward_kinematics_core import dhfk_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // joint_angle[17:0], angle_offset[35:18], twist_angle[53:36],
   // link_length[77:54], link_offset[101:78], zero[103:102]
   input  logic [103:0]  req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // entry_index[3:0], entry_value[35:4], zero[39:36]
   output logic [39:0]   rsp_tdata,
   output logic          rsp_tlast
);

   dhfk_cmd_type       cmd;
   dhfk_status_type    status;
   logic [3:0]         entry_index;
   logic signed [31:0] entry_value;

   dhfk_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dhfk_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .joint_angle  (req_tdata[17:0]),
      .angle_offset (req_tdata[35:18]),
      .twist_angle  (req_tdata[53:36]),
      .link_length  (req_tdata[77:54]),
      .link_offset  (req_tdata[101:78]),
      .last_joint   (req_tlast),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .entry_index  (entry_index),
      .entry_value  (entry_value),
      .last_entry   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, entry_value, entry_index};

endmodule

// File: tb/dh_forward_kinematics_core_test.sv
// Self-checking stream testbench for the DH forward kinematics core with a built-in predictor.
module dh_forward_kinematics_core_test;
   import dhfk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 24;

   typedef struct packed {
      logic signed [17:0] joint_angle;
      logic signed [17:0] angle_offset;
      logic signed [17:0] twist_angle;
      logic signed [23:0] link_length;
      logic signed [23:0] link_offset;
      logic               last_joint;
   } joint_row_type;

   typedef struct packed {
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
      logic               last_entry;
   } entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [103:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tlast;

   joint_row_type joint_queue[$];
   entry_type     entry_queue[$];
   int            fail_count = 0;
   bit            quiet_phase = 1'b0;
   bit            in_taken = 1'b0;
   int            send_gap = 0;
   int            stall_left = 0;
   longint        chain[12];

   dh_forward_kinematics_core #(.CORDIC_STEPS(STEPS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint shift_down(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q30(longint p);
      return (p + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   task automatic sin_cos(input longint angle, output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      logic [31:0] phase;
      logic [31:0] probe;
      bit flip;
      r = angle % DEG360;
      if (r < 0) r += DEG360;
      phase = 32'(((r <<< 32) + 23040) / DEG360);
      probe = phase + 32'h4000_0000;
      flip = probe[31];
      if (flip) phase = phase + 32'h8000_0000;
      z = longint'(signed'(phase));
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = shift_down(y, i);
         dy = shift_down(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_value(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_value(5'(i)));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_unit(x);
      s = clamp_unit(y);
   endtask

   task automatic reset_chain();
      foreach (chain[k]) chain[k] = 0;
      chain[0] = Q30_ONE;
      chain[5] = Q30_ONE;
      chain[10] = Q30_ONE;
   endtask

   // Right-multiplies the joint transform into the chain and queues the entries on a last joint.
   task automatic predict_joint(input joint_row_type j);
      longint st, ct, sa, ca, acc;
      longint jr[9];
      longint jt[3];
      longint nt[12];
      entry_type e;
      sin_cos(longint'(j.joint_angle) + longint'(j.angle_offset), st, ct);
      sin_cos(longint'(j.twist_angle), sa, ca);
      jr[0] = ct; jr[1] = -round_q30(st * ca); jr[2] = round_q30(st * sa);
      jr[3] = st; jr[4] = round_q30(ct * ca);  jr[5] = -round_q30(ct * sa);
      jr[6] = 0;  jr[7] = sa;                  jr[8] = ca;
      jt[0] = round_q30(longint'(j.link_length) * ct);
      jt[1] = round_q30(longint'(j.link_length) * st);
      jt[2] = longint'(j.link_offset);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += chain[r*4+k] * jr[k*3+c];
            nt[r*4+c] = sat32(round_q30(acc));
         end
         acc = 0;
         for (int k = 0; k < 3; k++) acc += chain[r*4+k] * jt[k];
         nt[r*4+3] = sat32(round_q30(acc) + chain[r*4+3]);
      end
      chain = nt;
      if (j.last_joint) begin
         for (int k = 0; k < 12; k++) begin
            e.entry_index = 4'(k);
            e.entry_value = 32'(chain[k]);
            e.last_entry = (4'(k) == LAST_ENTRY);
            entry_queue.push_back(e);
         end
         reset_chain();
      end
   endtask

   function automatic logic signed [17:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 18'(-92160);
         1: return 18'(92160);
         2: return 18'($urandom);
         3: return 18'($urandom_range(0, 11520) - 5760);
         default: return 18'($urandom_range(0, 184320) - 92160);
      endcase
   endfunction

   function automatic logic signed [23:0] rand_length();
      case ($urandom_range(0, 5))
         0: return 24'h80_0000;
         1: return 24'h7f_ffff;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 131072) - 65536);
      endcase
   endfunction

   // Driver: each item is predicted when its handshake completes.
   always @(posedge clock) begin
      in_taken = !reset && req_tvalid && req_tready;
      if (in_taken) predict_joint(joint_queue.pop_front());
   end

   always @(negedge clock) begin
      joint_row_type j;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !in_taken) begin
         // hold the item until it is taken
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (joint_queue.size() > 0) begin
         j = joint_queue[0];
         req_tvalid <= 1'b1;
         req_tdata <= {2'b00, j.link_offset, j.link_length, j.twist_angle,
                       j.angle_offset, j.joint_angle};
         req_tlast <= j.last_joint;
         if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
         req_tvalid <= 1'b0;
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_phase && !reset && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      entry_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.entry_index = rsp_tdata[3:0];
         got.entry_value = rsp_tdata[35:4];
         got.last_entry = rsp_tlast;
         if (entry_queue.size() == 0) begin
            $error("unexpected entry index %0d value %0d", got.entry_index, got.entry_value);
            fail_count++;
         end else begin
            want = entry_queue.pop_front();
            if (got.entry_index !== want.entry_index) begin
               $error("entry_index expected %0d actual %0d", want.entry_index, got.entry_index);
               fail_count++;
            end
            if (got.entry_value !== want.entry_value) begin
               $error("entry_value expected %0d actual %0d", want.entry_value, got.entry_value);
               fail_count++;
            end
            if (got.last_entry !== want.last_entry) begin
               $error("last_entry expected %0d actual %0d", want.last_entry, got.last_entry);
               fail_count++;
            end
         end
      end
   end

   initial begin
      joint_row_type j;
      int chain_len;
      reset_chain();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: field extremes, zero chain, wrapped angles and a long chain of ten joints.
      j = '0; j.last_joint = 1'b1; joint_queue.push_back(j);
      j = '{18'(-92160), 18'(-92160), 18'(-92160), 24'h80_0000, 24'h80_0000, 1'b1};
      joint_queue.push_back(j);
      j = '{18'(92160), 18'(92160), 18'(92160), 24'h7f_ffff, 24'h7f_ffff, 1'b1};
      joint_queue.push_back(j);
      j = '{18'h1ffff, 18'h20000, 18'h1ffff, 24'h7f_ffff, 24'h80_0000, 1'b1};
      joint_queue.push_back(j);
      j = '{18'h20000, 18'h1ffff, 18'h20000, 24'h80_0000, 24'h7f_ffff, 1'b1};
      joint_queue.push_back(j);
      j = '{18'(11520), 18'(0), 18'(-11520), 24'd256, 24'd512, 1'b1};
      joint_queue.push_back(j);
      j = '{18'(23040), 18'(11520), 18'(34560), 24'h3ff_f00, 24'd1, 1'b1};
      joint_queue.push_back(j);
      for (int k = 0; k < 10; k++) begin
         j = '{18'(5760 * k), 18'(-2880), 18'(11520), 24'h7f_ffff, 24'h7f_ffff, k == 9};
         joint_queue.push_back(j);
      end

      // Random chains of one to six joints, each closed by a last joint.
      while (joint_queue.size() < 258) begin
         chain_len = $urandom_range(1, 6);
         for (int k = 0; k < chain_len; k++) begin
            j.joint_angle = rand_angle();
            j.angle_offset = rand_angle();
            j.twist_angle = rand_angle();
            j.link_length = rand_length();
            j.link_offset = rand_length();
            j.last_joint = (k == chain_len - 1);
            joint_queue.push_back(j);
         end
      end
      j = '0; j.last_joint = 1'b1; joint_queue.push_back(j);

      // The last part of the run goes without idling on either side.
      wait (joint_queue.size() < 30);
      quiet_phase = 1'b1;

      wait (joint_queue.size() == 0);
      wait (entry_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS dh_forward_kinematics_core");
      end else begin
         $display("FAIL dh_forward_kinematics_core");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL dh_forward_kinematics_core");
      $finish;
   end
endmodule

// File: files.f
design/dhfk_pkg.sv
design/dhfk_sincos.sv
design/dhfk_datapath.sv
design/dhfk_ctrl.sv
design/dh_forward_kinematics_core.sv
tb/dh_forward_kinematics_core_test.sv
